// File: rtl/core/jec_pkg.sv
// ----------------------------------------------------------------------------
// jec_pkg
// Shared constants for the joystick event conditioner: event type codes,
// item and record kinds, config register indexes and resets, saturation limits.
// ----------------------------------------------------------------------------
package jec_pkg;

  // event type codes after the init bit is masked off
  localparam logic [6:0] EVT_BUTTON = 7'd1;
  localparam logic [6:0] EVT_AXIS   = 7'd2;

  // item kinds on the input channel
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // record kinds on the output channel
  localparam logic REC_AXIS   = 1'b0;
  localparam logic REC_BUTTON = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COALESCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd3;

  // configuration reset values
  localparam logic [14:0] DEADZONE_RST = 15'd983;
  localparam logic [31:0] GAIN_RST     = 32'd67565;
  localparam logic [15:0] COALESCE_RST = 16'd20;
  localparam logic [15:0] REPEAT_RST   = 16'd0;

  // saturation limits of the Q1.15 result magnitude
  localparam logic [32:0] MAG_POS_LIM = 33'd32767;
  localparam logic [32:0] MAG_NEG_LIM = 33'd32768;

  // control handed from the conditioning pipe to the axis memory
  typedef struct packed {
    logic        valid;
    logic [4:0]  idx;
  } jec_wr_ctl_t;

endpackage

// File: rtl/core/joystick_event_conditioner.sv
// ----------------------------------------------------------------------------
// joystick_event_conditioner
// Joystick event conditioning: deadzone, gain and coalescing of axis events,
// button tracking, repeat timing and snapshot publishing via an axis memory.
// ----------------------------------------------------------------------------
// Publish: an accepted publishing item first reads axis entry zero, then
//   sends one record per cycle (NUM_AXES + 1 records) unless stalled.
// Input: a tick without publish leaves the input free; an axis event stalls
//   it through the three-stage conditioning pipe and the memory write, and a
//   publish until its button record loads (single memory read port).
// Reset: registers return to their defaults and block state clears; axis
//   entries read as zero until written (per-entry valid bits, no sweep).
module joystick_event_conditioner #(
  parameter int unsigned NUM_AXES    = 8,
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    event_type_i,
  input  logic [7:0]                    control_index_i,
  input  logic signed [15:0]            raw_value_i,
  input  logic [31:0]                   event_stamp_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          record_kind_o,
  output logic [2:0]                    axis_index_o,
  output logic signed [15:0]            axis_value_o,
  output logic [15:0]                   button_word_o,
  output logic [31:0]                   snapshot_stamp_o,
  output logic                          last_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [jec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);
  import jec_pkg::*;

  localparam int unsigned AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned BTW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND,
    ST_PUB_RD,
    ST_PUB_AX,
    ST_PUB_BTN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [14:0] deadzone_q;
  logic [31:0] gain_q;
  logic [15:0] coalesce_q;
  logic [15:0] repeat_q;

  // block state
  logic [NUM_BUTTONS-1:0] buttons_q;
  logic [31:0]            stamp_q;
  logic                   pending_q, pending_d;
  logic                   armed_q, armed_d;
  logic [15:0]            count_q, count_d;
  logic [AXW-1:0]         pub_idx_q;

  // output register
  logic               out_valid_q;
  logic               rec_kind_q;
  logic [2:0]         axis_index_q;
  logic signed [15:0] axis_value_q;
  logic [15:0]        button_word_q;
  logic [31:0]        snap_stamp_q;
  logic               last_q;

  // axis memory
  logic [15:0]         axis_mem [NUM_AXES];
  logic [NUM_AXES-1:0] axis_vld_q;
  logic [15:0]         rd_data_q;
  logic                rd_vld_q;
  logic                rd_en;
  logic [AXW-1:0]      rd_addr;

  // conditioning pipe
  jec_wr_ctl_t        cond_in, cond_out;
  logic signed [15:0] cond_value;

  logic       in_acc, can_load, out_load;
  logic [6:0] evt_type;
  logic       is_btn, is_axis, now, soon;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign out_load   = can_load && (state_q inside {ST_PUB_AX, ST_PUB_BTN});

  // decode of the accepted item
  always_comb begin
    evt_type = event_type_i[6:0];
    is_btn   = (kind_i == KIND_EVENT) && (evt_type == EVT_BUTTON)
               && (control_index_i < 8'(NUM_BUTTONS));
    is_axis  = (kind_i == KIND_EVENT) && (evt_type == EVT_AXIS)
               && (control_index_i < 8'(NUM_AXES));
  end

  // timer update, publish decision and arming
  always_comb begin
    now       = 1'b0;
    soon      = is_axis;
    pending_d = pending_q;
    armed_d   = armed_q;
    count_d   = count_q;
    if (kind_i == KIND_EVENT) begin
      now = is_btn;
    end else if (armed_q) begin
      if (count_q <= 16'd1) begin
        count_d = '0;
        now     = 1'b1;
      end else begin
        count_d = count_q - 16'd1;
      end
    end
    if (now) begin
      pending_d = 1'b0;
      armed_d   = 1'b0;
    end
    if (!pending_d && soon) begin
      count_d   = coalesce_q;
      pending_d = 1'b1;
      armed_d   = 1'b1;
    end
    if (!armed_d && (repeat_q != 16'd0)) begin
      count_d = repeat_q;
      armed_d = 1'b1;
    end
  end

  // conditioning pipe start
  always_comb begin
    cond_in       = '0;
    cond_in.valid = in_acc && is_axis;
    cond_in.idx   = 5'(control_index_i);
  end

  jec_axis_cond u_cond (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cond_in),
    .value_i    (raw_value_i),
    .deadzone_i (deadzone_q),
    .gain_i     (gain_q),
    .ctl_o      (cond_out),
    .value_o    (cond_value)
  );

  // read port of the axis memory during publish
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pub_idx_q;
    if (state_q == ST_PUB_RD) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if ((state_q == ST_PUB_AX) && can_load
                 && (pub_idx_q != AXW'(NUM_AXES - 1))) begin
      rd_en   = 1'b1;
      rd_addr = pub_idx_q + AXW'(1);
    end
  end

  // axis memory storage
  always_ff @(posedge clk_i) begin
    if (cond_out.valid) begin
      axis_mem[cond_out.idx[AXW-1:0]] <= cond_value;
    end
    if (rd_en) begin
      rd_data_q <= axis_mem[rd_addr];
    end
  end

  // entry valid bits and read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cond_out.valid) begin
        axis_vld_q[cond_out.idx[AXW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= axis_vld_q[rd_addr];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      gain_q     <= GAIN_RST;
      coalesce_q <= COALESCE_RST;
      repeat_q   <= REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADZONE: deadzone_q <= cfg_wdata_i[14:0];
        CFG_GAIN:     gain_q     <= cfg_wdata_i;
        CFG_COALESCE: coalesce_q <= cfg_wdata_i[15:0];
        CFG_REPEAT:   repeat_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, block state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      buttons_q     <= '0;
      stamp_q       <= '0;
      pending_q     <= 1'b0;
      armed_q       <= 1'b0;
      count_q       <= '0;
      pub_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      rec_kind_q    <= REC_AXIS;
      axis_index_q  <= '0;
      axis_value_q  <= '0;
      button_word_q <= '0;
      snap_stamp_q  <= '0;
      last_q        <= 1'b0;
    end else begin
      // output valid: set on a record load, cleared once the record leaves
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pending_q <= pending_d;
            armed_q   <= armed_d;
            count_q   <= count_d;
            if (kind_i == KIND_EVENT) begin
              stamp_q <= event_stamp_i;
            end
            if (is_btn) begin
              buttons_q[control_index_i[BTW-1:0]] <= (raw_value_i != 16'sd0);
            end
            if (now) begin
              state_q <= ST_PUB_RD;
            end else if (is_axis) begin
              state_q <= ST_COND;
            end
          end
        end
        ST_COND: begin
          if (cond_out.valid) begin
            state_q <= ST_IDLE;
          end
        end
        ST_PUB_RD: begin
          pub_idx_q <= '0;
          state_q   <= ST_PUB_AX;
        end
        ST_PUB_AX: begin
          if (can_load) begin
            rec_kind_q    <= REC_AXIS;
            axis_index_q  <= 3'(pub_idx_q);
            axis_value_q  <= rd_vld_q ? rd_data_q : 16'sd0;
            button_word_q <= '0;
            snap_stamp_q  <= stamp_q;
            last_q        <= 1'b0;
            if (pub_idx_q == AXW'(NUM_AXES - 1)) begin
              state_q <= ST_PUB_BTN;
            end else begin
              pub_idx_q <= pub_idx_q + AXW'(1);
            end
          end
        end
        ST_PUB_BTN: begin
          if (can_load) begin
            rec_kind_q    <= REC_BUTTON;
            axis_index_q  <= '0;
            axis_value_q  <= '0;
            button_word_q <= 16'(buttons_q);
            snap_stamp_q  <= stamp_q;
            last_q        <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign record_kind_o    = rec_kind_q;
  assign axis_index_o     = axis_index_q;
  assign axis_value_o     = axis_value_q;
  assign button_word_o    = button_word_q;
  assign snapshot_stamp_o = snap_stamp_q;
  assign last_o           = last_q;

  // memory writes only come back while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cond_out.valid |-> (state_q == ST_COND))
    else $error("axis write outside conditioning wait");

  // a pending coalesce always has its timer armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> armed_q)
    else $error("coalesce pending without armed timer");

  // a publish starts only from an idle block and reads entry zero first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUB_AX) && $past(state_q == ST_PUB_RD) |-> (pub_idx_q == '0))
    else $error("publish did not start at axis zero");

  // the button record closes every snapshot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (record_kind_o == REC_BUTTON))
    else $error("snapshot closed by an axis record");

endmodule

// File: rtl/core/jec_axis_cond.sv
// ----------------------------------------------------------------------------
// jec_axis_cond
// Three-stage axis conditioning pipe: deadzone removal, gain multiply,
// rounding with inversion and saturation to Q1.15.
// ----------------------------------------------------------------------------
module jec_axis_cond (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jec_pkg::jec_wr_ctl_t ctl_i,
  input  logic signed [15:0]  value_i,
  input  logic [14:0]         deadzone_i,
  input  logic [31:0]         gain_i,
  output jec_pkg::jec_wr_ctl_t ctl_o,
  output logic signed [15:0]  value_o
);
  import jec_pkg::*;

  jec_wr_ctl_t        s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [15:0]        s1_mag_q, s1_mag_d;
  logic               s1_pos_q, s1_pos_d;
  logic [47:0]        s2_prod_q;
  logic               s2_pos_q;
  logic signed [15:0] s3_val_q, s3_val_d;

  logic signed [17:0] v_ext, d_ext, a_val;
  logic [32:0]        m_val;

  // deadzone removal and magnitude
  always_comb begin
    v_ext    = 18'(value_i);
    d_ext    = $signed({3'b000, deadzone_i});
    a_val    = '0;
    s1_pos_d = 1'b0;
    if (v_ext > d_ext) begin
      a_val    = v_ext - d_ext;
      s1_pos_d = 1'b1;
    end else if (v_ext < -d_ext) begin
      a_val    = -(v_ext + d_ext);
    end
    s1_mag_d = a_val[15:0];
  end

  // round half up, invert and saturate
  always_comb begin
    m_val = 33'((49'(s2_prod_q) + 49'd32768) >> 16);
    if (s2_pos_q) begin
      if (m_val > MAG_NEG_LIM) s3_val_d = 16'sh8000;
      else                      s3_val_d = 16'(-m_val);
    end else begin
      if (m_val > MAG_POS_LIM) s3_val_d = 16'sh7fff;
      else                      s3_val_d = 16'(m_val);
    end
  end

  // pipe control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // pipe data
  always_ff @(posedge clk_i) begin
    s1_mag_q  <= s1_mag_d;
    s1_pos_q  <= s1_pos_d;
    s2_prod_q <= 48'(s1_mag_q) * 48'(gain_i);
    s2_pos_q  <= s1_pos_q;
    s3_val_q  <= s3_val_d;
  end

  assign ctl_o   = s3_ctl_q;
  assign value_o = s3_val_q;

endmodule
